// ===== rtl/fat12_cluster_allocator_macros.svh =====
// Assertion macros used by the allocator checker.
`ifndef FAT12_CLUSTER_ALLOCATOR_MACROS_SVH
`define FAT12_CLUSTER_ALLOCATOR_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high
`define FCA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high
`define FCA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/fat12ca_pkg.sv =====
// Types and codes shared by the FAT12 cluster allocator and its checker.
`default_nettype none

package fat12ca_pkg;

  // Cluster number / table entry
  typedef logic [11:0] cl_t;

  // Operation codes carried on mode
  localparam logic [1:0] MODE_READ  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_FREE  = 2'd2;
  localparam logic [1:0] MODE_ALLOC = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NO_RUN = 2'd1;
  localparam logic [1:0] ST_RANGE  = 2'd2;

  // Configuration register indexes
  localparam logic CFG_FIRST_ALLOC = 1'b0;
  localparam logic CFG_LAST_ALLOC  = 1'b1;

  // FAT12 link values
  localparam cl_t LINK_MIN   = 12'h002;
  localparam cl_t LINK_END   = 12'hFF8;
  localparam cl_t CHAIN_LAST = 12'hFFF;

endpackage

`default_nettype wire

// ===== rtl/fat12_cluster_allocator.sv =====
// Flow: a finished result waits in the sequencer while the output is stalled.
// Throughput: one transaction at a time; a single-port table memory with registered
//   read data is shared by the small sequencer, one entry touched per cycle.
// Reset: rst clears control and config; a clearing pass over every entry then
//   zeroes the table, with in_stall high until it ends.
`default_nettype none

module fat12_cluster_allocator #(
  parameter int NUM_ENTRIES = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration write port
  input  wire logic        cfg_write,
  input  wire logic        cfg_index,
  input  wire logic [7:0]  cfg_data,
  // input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  mode,
  input  wire logic [11:0] cluster,
  input  wire logic [11:0] value,
  input  wire logic [11:0] count,
  // output channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       status,
  output logic [11:0]      data
);

  localparam int AW = $clog2(NUM_ENTRIES);
  localparam logic [12:0] NUM_W = 13'(NUM_ENTRIES);
  localparam fat12ca_pkg::cl_t HI_MAX = 12'(NUM_ENTRIES - 1);
  localparam logic [AW-1:0] CLR_LAST = AW'(NUM_ENTRIES - 1);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_READ_WAIT,
    S_WRITE,
    S_FREE_CHK,
    S_FREE_WAIT,
    S_SCAN,
    S_LINK,
    S_DONE
  } state_t;

  state_t state;

  // config registers
  logic [7:0] first_alloc_cluster;
  logic [7:0] last_alloc_cluster;

  // operation registers
  logic [AW-1:0]        clr;
  fat12ca_pkg::cl_t     op_cluster;
  fat12ca_pkg::cl_t     op_value;
  fat12ca_pkg::cl_t     op_count;
  fat12ca_pkg::cl_t     walk;
  fat12ca_pkg::cl_t     scan_addr;
  fat12ca_pkg::cl_t     chk_addr;
  logic                 chk_valid;
  fat12ca_pkg::cl_t     run;
  fat12ca_pkg::cl_t     run_end;
  fat12ca_pkg::cl_t     run_first;
  logic [1:0]           res_status;
  fat12ca_pkg::cl_t     res_data;

  // table memory
  fat12ca_pkg::cl_t     mem [NUM_ENTRIES];
  fat12ca_pkg::cl_t     rdata;
  logic                 mem_we;
  logic [AW-1:0]        mem_addr;
  fat12ca_pkg::cl_t     mem_wdata;

  // derived values
  fat12ca_pkg::cl_t     alloc_lo;
  fat12ca_pkg::cl_t     alloc_hi;
  logic                 cl_in_table;
  logic                 walk_is_link;
  logic                 walk_in_table;
  fat12ca_pkg::cl_t     run_inc;
  logic                 scan_hit;
  logic                 out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  // allocation window, clamped to the table
  assign alloc_lo = (first_alloc_cluster < 8'd2) ? fat12ca_pkg::LINK_MIN
                                                 : {4'd0, first_alloc_cluster};
  assign alloc_hi = ({5'd0, last_alloc_cluster} >= NUM_W) ? HI_MAX
                                                         : {4'd0, last_alloc_cluster};

  assign cl_in_table   = ({1'b0, cluster} < NUM_W);
  assign walk_is_link  = (walk >= fat12ca_pkg::LINK_MIN) && (walk < fat12ca_pkg::LINK_END);
  assign walk_in_table = ({1'b0, walk} < NUM_W);

  // run tracking for the scan pipeline
  assign run_inc  = run + 12'd1;
  assign scan_hit = chk_valid && (rdata == '0) && (run_inc == op_count);

  // memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = walk[AW-1:0];
    mem_wdata = '0;
    case (state)
      S_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr;
      end
      S_READ: begin
        mem_addr = op_cluster[AW-1:0];
      end
      S_WRITE: begin
        mem_we    = 1'b1;
        mem_addr  = op_cluster[AW-1:0];
        mem_wdata = op_value;
      end
      S_FREE_CHK: begin
        mem_we = walk_is_link && walk_in_table;
      end
      S_SCAN: begin
        mem_addr = scan_addr[AW-1:0];
      end
      S_LINK: begin
        mem_we    = 1'b1;
        mem_wdata = (walk == run_end) ? fat12ca_pkg::CHAIN_LAST : (walk + 12'd1);
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // single-port table, old data read on a write
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rdata <= mem[mem_addr];
  end

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      first_alloc_cluster <= 8'd2;
      last_alloc_cluster  <= 8'd255;
    end else if (cfg_write) begin
      case (cfg_index)
        fat12ca_pkg::CFG_FIRST_ALLOC: first_alloc_cluster <= cfg_data;
        fat12ca_pkg::CFG_LAST_ALLOC:  last_alloc_cluster  <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr       <= '0;
      chk_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        // zero the table after reset
        S_CLEAR: begin
          clr <= clr + AW'(1);
          if (clr == CLR_LAST) begin
            state <= S_IDLE;
          end
        end

        // take a transaction and dispatch by mode
        S_IDLE: begin
          if (in_valid) begin
            op_cluster <= cluster;
            op_value   <= value;
            op_count   <= count;
            walk       <= cluster;
            res_data   <= '0;
            case (mode)
              fat12ca_pkg::MODE_READ: begin
                if (cl_in_table) begin
                  res_status <= fat12ca_pkg::ST_OK;
                  state      <= S_READ;
                end else begin
                  res_status <= fat12ca_pkg::ST_RANGE;
                  state      <= S_DONE;
                end
              end
              fat12ca_pkg::MODE_WRITE: begin
                if (cl_in_table) begin
                  res_status <= fat12ca_pkg::ST_OK;
                  state      <= S_WRITE;
                end else begin
                  res_status <= fat12ca_pkg::ST_RANGE;
                  state      <= S_DONE;
                end
              end
              fat12ca_pkg::MODE_FREE: begin
                res_status <= fat12ca_pkg::ST_OK;
                state      <= S_FREE_CHK;
              end
              fat12ca_pkg::MODE_ALLOC: begin
                scan_addr <= alloc_lo;
                chk_valid <= 1'b0;
                run       <= '0;
                if (count == '0) begin
                  res_status <= fat12ca_pkg::ST_NO_RUN;
                  state      <= S_DONE;
                end else begin
                  res_status <= fat12ca_pkg::ST_OK;
                  state      <= S_SCAN;
                end
              end
              default: state <= S_IDLE;
            endcase
          end
        end

        S_READ: begin
          state <= S_READ_WAIT;
        end

        S_READ_WAIT: begin
          res_data <= rdata;
          state    <= S_DONE;
        end

        S_WRITE: begin
          state <= S_DONE;
        end

        // walk the chain, zeroing as we go
        S_FREE_CHK: begin
          if (!walk_is_link) begin
            state <= S_DONE;
          end else if (!walk_in_table) begin
            res_status <= fat12ca_pkg::ST_RANGE;
            state      <= S_DONE;
          end else begin
            state <= S_FREE_WAIT;
          end
        end

        S_FREE_WAIT: begin
          walk  <= rdata;
          state <= S_FREE_CHK;
        end

        // pipelined scan: issue one address, check the previous one
        S_SCAN: begin
          if (scan_hit) begin
            run_end   <= chk_addr;
            run_first <= chk_addr + 12'd1 - op_count;
            walk      <= chk_addr + 12'd1 - op_count;
            chk_valid <= 1'b0;
            state     <= S_LINK;
          end else begin
            if (chk_valid) begin
              run <= (rdata != '0) ? '0 : run_inc;
            end
            if (scan_addr <= alloc_hi) begin
              chk_addr  <= scan_addr;
              scan_addr <= scan_addr + 12'd1;
              chk_valid <= 1'b1;
            end else begin
              chk_valid <= 1'b0;
              if (!chk_valid) begin
                res_status <= fat12ca_pkg::ST_NO_RUN;
                state      <= S_DONE;
              end
            end
          end
        end

        // link the run, one entry per cycle
        S_LINK: begin
          walk <= walk + 12'd1;
          if (walk == run_end) begin
            res_data <= run_first;
            state    <= S_DONE;
          end
        end

        // hand the result to the output register
        S_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            status    <= res_status;
            data      <= res_data;
            state     <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/fat12ca_checker.sv =====
// Port-level checker for the FAT12 cluster allocator, bound to the top level.
`default_nettype none
`include "fat12_cluster_allocator_macros.svh"

module fat12ca_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [1:0]  status,
  input wire logic [11:0] data
);

  // a stalled result holds
  `FCA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(status) && $stable(data), "stalled result changed")

  // every failing result reports zero data
  `FCA_ASSERT_NOW(a_fail_data_zero, out_valid && (status != fat12ca_pkg::ST_OK), data == 12'd0, "failed transaction with nonzero data")

  // an accepted transaction keeps the block busy for at least the next cycle
  `FCA_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "second transaction taken right after accept")

  // a fresh result never appears in the cycle right after acceptance
  `FCA_ASSERT_NEXT(a_no_instant_result, in_valid && !in_stall && !out_valid, !out_valid, "result appeared one cycle after accept")

endmodule

bind fat12_cluster_allocator fat12ca_checker u_fat12ca_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .status    (status),
  .data      (data)
);

`default_nettype wire
